### design/acw_pkg.sv
// Shared constants for the ADC cosine color wheel: field widths, phase offsets,
// fixed-point angle constants and reciprocal multipliers for the series terms.
// No dependencies.
`default_nettype none

package acw_pkg;

    localparam int unsigned ADC_W = 12;
    localparam int unsigned DUTY_W = 12;

    localparam int unsigned SAMPLE_BITS_DEF = 12;
    localparam int unsigned DUTY_HALF_SCALE_DEF = 1024;

    // Phase offsets of the green and blue channels, in converter counts.
    localparam int unsigned GREEN_SHIFT = 1365;
    localparam int unsigned BLUE_SHIFT = 2731;

    // 0.0015332 rad per count in Q0.24; pi and 2*pi in Q13.
    localparam logic [14:0] SCALE_Q24 = 15'd25723;
    localparam logic [15:0] PI_Q13 = 16'd25736;
    localparam logic [16:0] TWO_PI_Q13 = 17'd51472;

    // 2.0 in Q14: the one of the cosine plus the one of the duty offset.
    localparam logic [19:0] TWO_Q14 = 20'd32768;

    // Rounding offsets of the fixed-point steps.
    localparam logic [26:0] ANGLE_RND = 27'd1024;
    localparam logic [29:0] X2_RND = 30'd2048;
    localparam int unsigned Q14_RND = 8192;

    // Exact floor division by multiplication: floor(n/d) = (n*M) >> K with
    // M = ceil(2^K/d), valid for every n below 2^(K - ceil(log2 d)).
    localparam logic [21:0] RECIP_24 = 22'd2796203;       // K = 26, n < 2^21
    localparam logic [24:0] RECIP_720 = 25'd23860930;     // K = 34, n < 2^24
    localparam logic [28:0] RECIP_40320 = 29'd436314139;  // K = 44, n < 2^28

    // Half divisors for round-to-nearest, ties up.
    localparam logic [21:0] HALF_24 = 22'd12;
    localparam logic [25:0] HALF_720 = 26'd360;
    localparam logic [29:0] HALF_40320 = 30'd20160;

    localparam int unsigned DUTY_FIELD_MAX = 4095;

    // Register stages from an accepted item to its result.
    localparam int unsigned LANE_LATENCY = 10;

endpackage

`default_nettype wire

### design/acw_cos_lane.sv
// One color channel: phase offset, angle scaling and folding, degree-8 Taylor
// cosine and duty scaling in a ten-stage pipeline. Depends on acw_pkg.
`default_nettype none

module acw_cos_lane #(
    parameter int unsigned PHASE_SHIFT = 0,
    parameter int unsigned DUTY_HALF_SCALE = acw_pkg::DUTY_HALF_SCALE_DEF
) (
    input  logic                        i_clk,
    input  logic [acw_pkg::ADC_W-1:0]   i_sample,
    output logic [acw_pkg::DUTY_W-1:0]  o_duty
);
    import acw_pkg::*;

    localparam logic [ADC_W-1:0] SHIFT_C = ADC_W'(PHASE_SHIFT);
    localparam logic [15:0] DHS_C = 16'(DUTY_HALF_SCALE);
    localparam logic [17:0] DUTY_CAP = 18'(2 * DUTY_HALF_SCALE);

    // Stage registers and their next values.
    logic [11:0] s1_mag;
    logic [26:0] r_prod, n_prod;
    logic [26:0] s2_sum;
    logic [15:0] s2_q;
    logic [14:0] r_ax, n_ax;
    logic [29:0] s3_sum;
    logic [17:0] r_x2, n_x2;
    logic [17:0] s4_hsum;
    logic [35:0] r_p4, n_p4;
    logic [17:0] r_x2_4, n_x2_4;
    logic [16:0] r_h2_4, n_h2_4;
    logic [35:0] s5_sum;
    logic [21:0] s5_x4;
    logic [39:0] r_p6, n_p6;
    logic [43:0] r_m4, n_m4;
    logic [17:0] r_x2_5, n_x2_5;
    logic [16:0] r_h2_5, n_h2_5;
    logic [39:0] s6_sum;
    logic [25:0] s6_x6;
    logic [43:0] r_p8, n_p8;
    logic [49:0] r_m6, n_m6;
    logic [17:0] r_t4_6, n_t4_6;
    logic [16:0] r_h2_6, n_h2_6;
    logic [43:0] s7_sum;
    logic [29:0] s7_x8;
    logic [57:0] r_m8, n_m8;
    logic [15:0] r_t6, n_t6;
    logic [17:0] r_t4_7, n_t4_7;
    logic [16:0] r_h2_7, n_h2_7;
    logic [13:0] s8_t8;
    logic [19:0] r_sum, n_sum;
    logic        s9_pos;
    logic [31:0] r_dprod, n_dprod;
    logic [17:0] s10_d;
    logic [17:0] s10_dcap;
    logic [DUTY_W-1:0] r_duty, n_duty;

    // Stage 1: the cosine is even, so only the magnitude of the phase matters.
    always_comb begin
        s1_mag = (i_sample < SHIFT_C) ? (SHIFT_C - i_sample) : (i_sample - SHIFT_C);
        n_prod = 27'(s1_mag) * 27'(SCALE_Q24);
    end

    // Stage 2: round to Q13, then fold by one period. With a 12-bit sample the
    // rounded magnitude stays below 2*pi, so the folded angle always fits Q3.13.
    always_comb begin
        s2_sum = r_prod + ANGLE_RND;
        s2_q = s2_sum[26:11];
        n_ax = (s2_q > PI_Q13) ? 15'(TWO_PI_Q13 - 17'(s2_q)) : s2_q[14:0];
    end

    // Stage 3: x^2 in Q14.
    always_comb begin
        s3_sum = (30'(r_ax) * 30'(r_ax)) + X2_RND;
        n_x2 = s3_sum[29:12];
    end

    // Stage 4: x^4 product and the rounded x^2/2 term.
    always_comb begin
        n_p4 = 36'(r_x2) * 36'(r_x2);
        n_x2_4 = r_x2;
        s4_hsum = r_x2 + 18'd1;
        n_h2_4 = s4_hsum[17:1];
    end

    // Stage 5: round x^4, start x^6 and the x^4/24 term.
    always_comb begin
        s5_sum = r_p4 + 36'(Q14_RND);
        s5_x4 = s5_sum[35:14];
        n_p6 = 40'(s5_x4) * 40'(r_x2_4);
        n_m4 = 44'(s5_x4 + HALF_24) * 44'(RECIP_24);
        n_x2_5 = r_x2_4;
        n_h2_5 = r_h2_4;
    end

    // Stage 6: round x^6, start x^8 and the x^6/720 term.
    always_comb begin
        s6_sum = r_p6 + 40'(Q14_RND);
        s6_x6 = s6_sum[39:14];
        n_p8 = 44'(s6_x6) * 44'(r_x2_5);
        n_m6 = 50'(s6_x6 + HALF_720) * 50'(RECIP_720);
        n_t4_6 = r_m4[43:26];
        n_h2_6 = r_h2_5;
    end

    // Stage 7: round x^8 and start the x^8/40320 term.
    always_comb begin
        s7_sum = r_p8 + 44'(Q14_RND);
        s7_x8 = s7_sum[43:14];
        n_m8 = 58'(s7_x8 + HALF_40320) * 58'(RECIP_40320);
        n_t6 = r_m6[49:34];
        n_t4_7 = r_t4_6;
        n_h2_7 = r_h2_6;
    end

    // Stage 8: 1 + cos in Q14, as a two's complement value.
    always_comb begin
        s8_t8 = r_m8[57:44];
        n_sum = TWO_Q14 - 20'(r_h2_7) + 20'(r_t4_7) - 20'(r_t6) + 20'(s8_t8);
    end

    // Stage 9: scale by the half range; a sum at or below zero gives zero.
    always_comb begin
        s9_pos = !r_sum[19] && (r_sum != 20'd0);
        n_dprod = s9_pos ? (32'(r_sum[15:0]) * 32'(DHS_C)) : 32'd0;
    end

    // Stage 10: truncate and saturate to the full range and to the field.
    always_comb begin
        s10_d = r_dprod[31:14];
        s10_dcap = (s10_d > DUTY_CAP) ? DUTY_CAP : s10_d;
        n_duty = (s10_dcap > 18'(DUTY_FIELD_MAX)) ? DUTY_W'(DUTY_FIELD_MAX)
                                                  : s10_dcap[DUTY_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        r_prod  <= n_prod;
        r_ax    <= n_ax;
        r_x2    <= n_x2;
        r_p4    <= n_p4;
        r_x2_4  <= n_x2_4;
        r_h2_4  <= n_h2_4;
        r_p6    <= n_p6;
        r_m4    <= n_m4;
        r_x2_5  <= n_x2_5;
        r_h2_5  <= n_h2_5;
        r_p8    <= n_p8;
        r_m6    <= n_m6;
        r_t4_6  <= n_t4_6;
        r_h2_6  <= n_h2_6;
        r_m8    <= n_m8;
        r_t6    <= n_t6;
        r_t4_7  <= n_t4_7;
        r_h2_7  <= n_h2_7;
        r_sum   <= n_sum;
        r_dprod <= n_dprod;
        r_duty  <= n_duty;
    end

    assign o_duty = r_duty;

endmodule

`default_nettype wire

### design/adc_cosine_color_wheel_core.sv
// Top level of the ADC cosine color wheel: three cosine lanes and the valid
// pipeline that marks their results. Depends on acw_pkg and acw_cos_lane.
`default_nettype none

// Takes one converter sample per cycle and returns red, green and blue PWM duty
// values, each 1024*(1 + cos) of the sample's angle at 0.0015332 rad per count,
// with green and blue offset by 1365 and 2731 counts. busy is always low: a new
// item can be started in every cycle. Each result appears after the full depth
// of the cosine pipeline, with o_strobe high for a single cycle alongside it;
// results must be taken when shown, since they cannot be held.
module adc_cosine_color_wheel_core #(
    parameter int unsigned SAMPLE_BITS = acw_pkg::SAMPLE_BITS_DEF,
    parameter int unsigned DUTY_HALF_SCALE = acw_pkg::DUTY_HALF_SCALE_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [acw_pkg::ADC_W-1:0]   i_adc_sample,
    output logic                        o_strobe,
    output logic [acw_pkg::DUTY_W-1:0]  o_red_duty,
    output logic [acw_pkg::DUTY_W-1:0]  o_green_duty,
    output logic [acw_pkg::DUTY_W-1:0]  o_blue_duty
);
    import acw_pkg::*;

    localparam int unsigned SB_EFF = (SAMPLE_BITS < ADC_W) ? SAMPLE_BITS : ADC_W;
    localparam logic [ADC_W-1:0] SAMPLE_MASK = ADC_W'((1 << SB_EFF) - 1);

    logic [ADC_W-1:0] sample;
    logic [LANE_LATENCY-1:0] r_vld, n_vld;

    assign sample = i_adc_sample & SAMPLE_MASK;
    assign busy = 1'b0;

    always_comb begin
        n_vld = {r_vld[LANE_LATENCY-2:0], start};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_strobe = r_vld[LANE_LATENCY-1];

    acw_cos_lane #(
        .PHASE_SHIFT     (0),
        .DUTY_HALF_SCALE (DUTY_HALF_SCALE)
    ) u_red (
        .i_clk    (i_clk),
        .i_sample (sample),
        .o_duty   (o_red_duty)
    );

    acw_cos_lane #(
        .PHASE_SHIFT     (GREEN_SHIFT),
        .DUTY_HALF_SCALE (DUTY_HALF_SCALE)
    ) u_green (
        .i_clk    (i_clk),
        .i_sample (sample),
        .o_duty   (o_green_duty)
    );

    acw_cos_lane #(
        .PHASE_SHIFT     (BLUE_SHIFT),
        .DUTY_HALF_SCALE (DUTY_HALF_SCALE)
    ) u_blue (
        .i_clk    (i_clk),
        .i_sample (sample),
        .o_duty   (o_blue_duty)
    );

endmodule

`default_nettype wire
